// ----- rtl/hdt_pkg.sv -----
`timescale 1ns / 1ps

package hdt_pkg;

	localparam int SYM_W  = 8;
	localparam int BITS_W = 16;
	localparam int LEN_W  = 5;
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_DECODE = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_EMPTY        = 3'd1,
		ST_THROUGH_LEAF = 3'd2,
		ST_DUPLICATE    = 3'd3,
		ST_FULL         = 3'd4,
		ST_BAD_BRANCH   = 3'd5,
		ST_TRUNCATED    = 3'd6,
		ST_BLOCKED      = 3'd7
	} status_t;

	// Classified item as it leaves the front queue
	typedef struct packed {
		op_t               op;
		logic              bad_code;
		logic [SYM_W-1:0]  sym;
		logic [BITS_W-1:0] bits;
		logic [LEN_W-1:0]  pos;
		logic              bit_req;
	} cmd_t;

endpackage

// ----- rtl/hdt_ram.sv -----
`timescale 1ns / 1ps

module hdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/hdt_front.sv -----
`timescale 1ns / 1ps

module hdt_front import hdt_pkg::*; #(
	parameter int MAX_CODE_LEN = 16,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // symbol[7:0], code_bits[23:8], code_len[28:24], bit_req[29]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        q_valid,
	input  logic        q_pop,
	output cmd_t        q_cmd
);

	cmd_t             in_cmd;
	logic [LEN_W-1:0] in_len;
	cmd_t             entry_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_AW:0]    cnt_q;
	logic             push;

	// Classify: decode the opcode and check the code header once, here
	always_comb begin
		in_len          = s_tdata[28:24];
		in_cmd.op       = op_t'(s_tuser);
		in_cmd.sym      = s_tdata[7:0];
		in_cmd.bits     = s_tdata[23:8];
		in_cmd.pos      = in_len - LEN_W'(1);
		in_cmd.bit_req  = s_tdata[29];
		in_cmd.bad_code = (in_len == '0) || (32'(in_len) > 32'(MAX_CODE_LEN)) ||
			(32'(s_tdata[7:0]) >= 32'(SYMBOL_COUNT));
	end

	assign s_tready = (cnt_q != (Q_AW+1)'(Q_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != '0);
	assign q_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + (Q_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/hdt_back.sv -----
`timescale 1ns / 1ps

module hdt_back import hdt_pkg::*; #(
	parameter int MAX_NODES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // symbol_out[7:0], status[10:8]
	output logic        m_tuser    // symbol_valid
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);

	typedef struct packed {
		logic [NW-1:0]    left;
		logic [NW-1:0]    right;
		logic             leaf;
		logic [SYM_W-1:0] sym;
	} node_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_EV,
		S_INS_UPD,
		S_DEC_EV,
		S_DEC_LEAF
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     used_q;
	logic [NW-1:0]     position_q;
	logic              hfault_q;
	logic              sfault_q;
	logic [NW-1:0]     cur_q;
	logic [NW-1:0]     new_q;
	logic [NW-1:0]     next_q;
	node_t             par_q;
	logic [SYM_W-1:0]  sym_q;
	logic [BITS_W-1:0] bits_q;
	logic [LEN_W-1:0]  pos_q;
	logic              bit_q;

	logic              out_valid_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_hit_q;
	status_t           out_status_q;

	logic              ram_we;
	logic [NW-1:0]     ram_waddr;
	node_t             ram_wdata;
	logic              ram_re;
	logic [NW-1:0]     ram_raddr;
	logic [$bits(node_t)-1:0] ram_rdata;
	node_t             rnode;

	logic              out_free;
	logic              done;
	logic              start_multi;
	status_t           res_status;
	logic [SYM_W-1:0]  res_sym;
	logic              res_hit;
	logic              ins_bit;
	logic              ins_last;
	logic [NW-1:0]     ins_next;
	logic              full;
	logic [NW-1:0]     dec_next;
	logic              dec_bad;
	logic [NW-1:0]     dec_root;
	node_t             par_link;

	hdt_ram #(
		.WIDTH ($bits(node_t)),
		.DEPTH (MAX_NODES)
	) u_nodes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rnode    = ram_rdata;
	assign out_free = !out_valid_q || m_tready;
	assign ins_bit  = pos_q[LEN_W-1] ? 1'b0 : bits_q[pos_q[3:0]];
	assign ins_last = (pos_q == '0);
	assign ins_next = ins_bit ? rnode.right : rnode.left;
	assign full     = (used_q >= CW'(MAX_NODES));
	assign dec_next = bit_q ? rnode.right : rnode.left;
	assign dec_bad  = (dec_next == '0) || (CW'(dec_next) >= used_q);
	assign dec_root = (CW'(position_q) < used_q) ? position_q : '0;

	// parent node with the freshly allocated child linked in
	always_comb begin
		par_link = rnode;
		if (ins_bit) begin
			par_link.right = used_q[NW-1:0];
		end else begin
			par_link.left = used_q[NW-1:0];
		end
	end

	always_comb begin
		done        = 1'b0;
		start_multi = 1'b0;
		res_status  = ST_OK;
		res_sym     = '0;
		res_hit     = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.op)
						OP_CLEAR: begin
							done = 1'b1;
						end
						OP_INSERT: begin
							if (hfault_q) begin
								done       = 1'b1;
								res_status = ST_BLOCKED;
							end else if (q_cmd.bad_code) begin
								done       = 1'b1;
								res_status = ST_EMPTY;
							end else begin
								start_multi = 1'b1;
								// empty tree: allocate the root first
								if (used_q == '0) begin
									ram_we = 1'b1;
								end
							end
						end
						OP_DECODE: begin
							if (hfault_q || sfault_q) begin
								done       = 1'b1;
								res_status = ST_BLOCKED;
							end else if (used_q == '0) begin
								done = 1'b1;
							end else begin
								start_multi = 1'b1;
								ram_re      = 1'b1;
								ram_raddr   = dec_root;
							end
						end
						OP_END: begin
							done = 1'b1;
							if (hfault_q || sfault_q) begin
								res_status = ST_BLOCKED;
							end else if (position_q != '0) begin
								res_status = ST_TRUNCATED;
							end
						end
					endcase
				end
			end
			S_INS_RD: begin
				ram_re    = 1'b1;
				ram_raddr = cur_q;
			end
			S_INS_EV: begin
				if (rnode.leaf) begin
					done       = 1'b1;
					res_status = ST_THROUGH_LEAF;
				end else if (ins_next != '0) begin
					if (ins_last) begin
						done       = 1'b1;
						res_status = ST_DUPLICATE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = ins_next;
					end
				end else if (full) begin
					done       = 1'b1;
					res_status = ST_FULL;
				end else begin
					ram_we         = 1'b1;
					ram_waddr      = used_q[NW-1:0];
					ram_wdata.leaf = ins_last;
					ram_wdata.sym  = ins_last ? sym_q : '0;
				end
			end
			S_INS_UPD: begin
				// link the new node into its parent
				ram_we    = 1'b1;
				ram_waddr = cur_q;
				ram_wdata = par_q;
				done      = ins_last;
			end
			S_DEC_EV: begin
				if (dec_bad) begin
					done       = 1'b1;
					res_status = ST_BAD_BRANCH;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = dec_next;
				end
			end
			S_DEC_LEAF: begin
				done = 1'b1;
				if (rnode.leaf) begin
					res_hit = 1'b1;
					res_sym = rnode.sym;
				end
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	assign q_pop = (state_q == S_IDLE) && q_valid && (start_multi || (done && out_free));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			position_q  <= '0;
			hfault_q    <= 1'b0;
			sfault_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= done;
				if (done) begin
					out_sym_q    <= res_sym;
					out_hit_q    <= res_hit;
					out_status_q <= res_status;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						unique case (q_cmd.op)
							OP_CLEAR: begin
								used_q     <= '0;
								position_q <= '0;
								hfault_q   <= 1'b0;
								sfault_q   <= 1'b0;
							end
							OP_INSERT: begin
								if (!hfault_q && q_cmd.bad_code) begin
									hfault_q <= 1'b1;
								end else if (!hfault_q) begin
									if (used_q == '0) begin
										used_q <= CW'(1);
									end
									cur_q   <= '0;
									sym_q   <= q_cmd.sym;
									bits_q  <= q_cmd.bits;
									pos_q   <= q_cmd.pos;
									state_q <= S_INS_RD;
								end
							end
							OP_DECODE: begin
								if (start_multi) begin
									bit_q   <= q_cmd.bit_req;
									state_q <= S_DEC_EV;
								end
							end
							OP_END: begin
								sfault_q   <= 1'b0;
								position_q <= '0;
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_EV;
				end
				S_INS_EV: begin
					if (done) begin
						if (out_free) begin
							hfault_q <= 1'b1;
							state_q  <= S_IDLE;
						end
					end else if (ins_next != '0) begin
						cur_q <= ins_next;
						pos_q <= pos_q - LEN_W'(1);
					end else begin
						used_q  <= used_q + CW'(1);
						new_q   <= used_q[NW-1:0];
						par_q   <= par_link;
						state_q <= S_INS_UPD;
					end
				end
				S_INS_UPD: begin
					if (done) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						cur_q   <= new_q;
						pos_q   <= pos_q - LEN_W'(1);
						state_q <= S_INS_RD;
					end
				end
				S_DEC_EV: begin
					if (done) begin
						if (out_free) begin
							sfault_q   <= 1'b1;
							position_q <= '0;
							state_q    <= S_IDLE;
						end
					end else begin
						next_q  <= dec_next;
						state_q <= S_DEC_LEAF;
					end
				end
				S_DEC_LEAF: begin
					if (out_free) begin
						position_q <= rnode.leaf ? '0 : next_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_status_q, out_sym_q};
	assign m_tuser  = out_hit_q;

`ifndef SYNTHESIS
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(MAX_NODES))
		else $error("node count beyond table size");

	a_position_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		(position_q != '0) |-> (CW'(position_q) < used_q))
		else $error("stream position points at an unallocated node");

	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_hit_q) |-> (out_status_q == ST_OK))
		else $error("decoded symbol carries an error status");

	a_walk_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_UPD) |-> (CW'(new_q) < used_q && CW'(cur_q) < used_q))
		else $error("insert links nodes outside the allocated range");
`endif

endmodule

// ----- rtl/huffman_tree_decoder.sv -----
`timescale 1ns / 1ps

// Bitwise code-tree decoder.
// Input channel s_*: one item per handshake; s_tuser selects clear, insert,
// decode-one-bit or end of stream, s_tdata carries symbol, code and bit.
// Output channel m_*: exactly one item per input item, in order; m_tuser flags
// a decoded symbol, m_tdata carries the symbol and a 3-bit status.
// A two-entry queue decouples the input from the sequencer, and a one-entry
// output register decouples the sequencer from the receiver, so input keeps
// flowing while a result waits.
// Steps per item, set by the node table's registered read port:
//   clear, end, blocked items and decodes on an empty tree: finish in the idle state
//   decode: read the current node, then the child; a missing branch ends after the first read
//   insert: read, allocate and link parent for each added node;
//     stepping over an existing node reads its child directly, an error ends the walk early
// Reset empties the tree and clears both faults; the node table is not swept.
// When m_tready stays low the result holds and the sequencer stalls on its
// next completion; the queue then fills and s_tready drops.
module huffman_tree_decoder import hdt_pkg::*; #(
	parameter int MAX_NODES    = 512,
	parameter int MAX_CODE_LEN = 16,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // symbol[7:0], code_bits[23:8], code_len[28:24], bit_req[29]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // symbol_out[7:0], status[10:8]
	output logic        m_tuser    // symbol_valid
);

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	hdt_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.SYMBOL_COUNT (SYMBOL_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_cmd    (q_cmd)
	);

	hdt_back #(
		.MAX_NODES (MAX_NODES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import hdt_pkg::*;

	localparam int TREE_NODES  = 512;
	localparam int CODE_MAX    = 16;
	localparam int ITEM_TARGET = 1950;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 60;

	typedef struct packed {
		op_t         func;
		logic [7:0]  symbol;
		logic [15:0] code_bits;
		logic [4:0]  code_len;
		logic        bit_req;
	} req_t;

	typedef struct packed {
		logic [7:0] symbol_out;
		logic       symbol_valid;
		status_t    status;
	} res_t;

	typedef struct packed {
		req_t rq;
		logic typed;
		res_t res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // symbol[7:0], code_bits[23:8], code_len[28:24], bit_req[29]
	logic [1:0]  s_tuser;   // func[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // symbol_out[7:0], status[10:8]
	logic        m_tuser;   // symbol_valid

	// shadow copy of the code tree
	int unsigned nd_left  [TREE_NODES];
	int unsigned nd_right [TREE_NODES];
	bit          nd_leaf  [TREE_NODES];
	logic [7:0]  nd_sym   [TREE_NODES];
	int unsigned nodes_live;
	int unsigned walk_pos;
	bit          hdr_fault;
	bit          strm_fault;

	res_t        pending_results[$];
	row_t        dir_tab[$];
	logic [15:0] cw_bits[$];
	int          cw_len[$];

	int mismatches = 0;
	int items_sent = 0;
	int quiet      = 0;
	int idle_pct   = 0;
	int stall_pct  = 0;
	bit hold_req   = 1'b0;

	huffman_tree_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned alloc_node(bit leaf, logic [7:0] sym);
		int unsigned idx;
		idx = nodes_live;
		nd_left[idx]  = 0;
		nd_right[idx] = 0;
		nd_leaf[idx]  = leaf;
		nd_sym[idx]   = sym;
		nodes_live++;
		return idx;
	endfunction

	function automatic status_t insert_code(logic [7:0] sym, logic [15:0] bits, int unsigned len);
		int unsigned cur;
		int unsigned nxt;
		bit b;
		bit last;
		if (len == 0 || len > CODE_MAX)
			return ST_EMPTY;
		if (nodes_live == 0)
			void'(alloc_node(1'b0, 8'h00));
		cur = 0;
		for (int i = 0; i < len; i++) begin
			b    = bits[len - 1 - i];
			nxt  = b ? nd_right[cur] : nd_left[cur];
			last = (i + 1 == len);
			if (last && nxt != 0)
				return ST_DUPLICATE;
			if (!last && nxt != 0) begin
				if (nd_leaf[nxt])
					return ST_THROUGH_LEAF;
				cur = nxt;
			end else begin
				if (nodes_live >= TREE_NODES)
					return ST_FULL;
				nxt = alloc_node(last, last ? sym : 8'h00);
				if (b)
					nd_right[cur] = nxt;
				else
					nd_left[cur] = nxt;
				cur = nxt;
			end
		end
		return ST_OK;
	endfunction

	// advance the shadow tree by one item and return the result it owes
	function automatic res_t tree_step(req_t rq);
		res_t r;
		int unsigned cur;
		int unsigned nxt;
		r.symbol_out   = 8'h00;
		r.symbol_valid = 1'b0;
		r.status       = ST_OK;
		case (rq.func)
			OP_CLEAR: begin
				nodes_live = 0;
				walk_pos   = 0;
				hdr_fault  = 1'b0;
				strm_fault = 1'b0;
			end
			OP_INSERT: begin
				if (hdr_fault) begin
					r.status = ST_BLOCKED;
				end else begin
					r.status = insert_code(rq.symbol, rq.code_bits, 32'(rq.code_len));
					if (r.status != ST_OK)
						hdr_fault = 1'b1;
				end
			end
			OP_DECODE: begin
				if (hdr_fault || strm_fault) begin
					r.status = ST_BLOCKED;
				end else if (nodes_live != 0) begin
					cur = (walk_pos < nodes_live) ? walk_pos : 0;
					nxt = rq.bit_req ? nd_right[cur] : nd_left[cur];
					if (nxt == 0 || nxt >= nodes_live) begin
						r.status   = ST_BAD_BRANCH;
						strm_fault = 1'b1;
						walk_pos   = 0;
					end else if (nd_leaf[nxt]) begin
						r.symbol_out   = nd_sym[nxt];
						r.symbol_valid = 1'b1;
						walk_pos       = 0;
					end else begin
						walk_pos = nxt;
					end
				end
			end
			default: begin
				if (hdr_fault || strm_fault)
					r.status = ST_BLOCKED;
				else if (walk_pos != 0)
					r.status = ST_TRUNCATED;
				strm_fault = 1'b0;
				walk_pos   = 0;
			end
		endcase
		return r;
	endfunction

	function automatic req_t mk_req(op_t f, logic [7:0] s, logic [15:0] b, logic [4:0] l,
			logic br);
		req_t rq;
		rq.func      = f;
		rq.symbol    = s;
		rq.code_bits = b;
		rq.code_len  = l;
		rq.bit_req   = br;
		return rq;
	endfunction

	function automatic void add_row(op_t f, logic [7:0] s, logic [15:0] b, logic [4:0] l,
			logic br, logic typed, logic [7:0] so, logic sv, status_t st);
		row_t r;
		r.rq                 = mk_req(f, s, b, l, br);
		r.typed              = typed;
		r.res.symbol_out     = so;
		r.res.symbol_valid   = sv;
		r.res.status         = st;
		dir_tab.push_back(r);
	endfunction

	task automatic send_item(req_t rq, logic typed, res_t tres);
		res_t want;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= rq.func;
		s_tdata  <= {2'b00, rq.bit_req, rq.code_len, rq.code_bits, rq.symbol};
		do @(posedge clk); while (!s_tready);
		want = tree_step(rq);
		pending_results.push_back(typed ? tres : want);
		items_sent++;
	endtask

	task automatic drive(op_t f, logic [7:0] s, logic [15:0] b, logic [4:0] l, logic br);
		send_item(mk_req(f, s, b, l, br), 1'b0, '0);
	endtask

	task automatic drive_noise();
		op_t f;
		f = op_t'($urandom_range(3));
		// keep clears rare so faults get to linger
		if (f == OP_CLEAR && $urandom_range(3) != 0)
			f = OP_DECODE;
		drive(f, 8'($urandom_range(255)), 16'($urandom_range(65535)),
			5'($urandom_range(31)), 1'($urandom_range(1)));
	endtask

	// random complete prefix code: split leaves until the count is reached or the tries run out
	task automatic build_code(int leaves, int depth, bit chain);
		int idx;
		int tries;
		logic [15:0] c;
		cw_bits.delete();
		cw_len.delete();
		cw_bits.push_back(16'h0000);
		cw_bits.push_back(16'h0001);
		cw_len.push_back(1);
		cw_len.push_back(1);
		tries = 0;
		while (cw_len.size() < leaves && tries < 400) begin
			idx = $urandom_range(cw_len.size() - 1);
			if (chain && $urandom_range(9) < 8)
				idx = cw_len.size() - 1;
			if (cw_len[idx] < depth) begin
				c = cw_bits[idx];
				cw_bits[idx] = {c[14:0], 1'b0};
				cw_bits.push_back({c[14:0], 1'b1});
				cw_len.push_back(cw_len[idx] + 1);
				cw_len[idx] = cw_len[idx] + 1;
			end
			tries++;
		end
	endtask

	task automatic load_code(int skip);
		logic [15:0] junk;
		for (int i = 0; i < cw_len.size(); i++) begin
			if (i != skip) begin
				// bits above the code length must be ignored
				junk = 16'($urandom_range(65535));
				drive(OP_INSERT, 8'($urandom_range(255)),
					(junk << cw_len[i]) | cw_bits[i], 5'(cw_len[i]),
					1'($urandom_range(1)));
			end
		end
	endtask

	task automatic send_codeword(int k, int nbits);
		logic [15:0] c;
		c = cw_bits[k];
		for (int j = cw_len[k] - 1; j >= cw_len[k] - nbits; j--)
			drive(OP_DECODE, 8'($urandom_range(255)), 16'($urandom_range(65535)),
				5'($urandom_range(31)), c[j]);
	endtask

	task automatic run_stream_episode(bit deep);
		int skip;
		int k;
		drive(OP_CLEAR, 8'($urandom_range(255)), 16'($urandom_range(65535)),
			5'($urandom_range(31)), 1'($urandom_range(1)));
		if (deep)
			build_code($urandom_range(17, 30), CODE_MAX, 1'b1);
		else
			build_code($urandom_range(2, 20), 6, 1'b0);
		skip = ($urandom_range(99) < 15) ? $urandom_range(cw_len.size() - 1) : -1;
		load_code(skip);
		repeat ($urandom_range(4, 20)) begin
			k = $urandom_range(cw_len.size() - 1);
			send_codeword(k, cw_len[k]);
			if ($urandom_range(99) < 3)
				drive_noise();
		end
		// cut the stream in the middle of a code now and then
		k = $urandom_range(cw_len.size() - 1);
		if ($urandom_range(99) < 30 && cw_len[k] > 1)
			send_codeword(k, $urandom_range(1, cw_len[k] - 1));
		drive(OP_END, 8'($urandom_range(255)), 16'($urandom_range(65535)),
			5'($urandom_range(31)), 1'($urandom_range(1)));
	endtask

	task automatic run_fill_episode();
		int n;
		drive(OP_CLEAR, 8'h00, 16'h0000, 5'd0, 1'b0);
		n = 0;
		while (n < 90 && !hdr_fault) begin
			drive(OP_INSERT, 8'($urandom_range(255)), 16'($urandom_range(65535)),
				5'(CODE_MAX), 1'($urandom_range(1)));
			n++;
		end
		repeat (3) drive_noise();
		drive(OP_END, 8'h00, 16'h0000, 5'd0, 1'b0);
	endtask

	task automatic set_idle_mode(int mode);
		case (mode)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 51;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 51;
			end
			default: begin
				idle_pct  = 23;
				stall_pct = 23;
			end
		endcase
	endtask

	initial begin
		row_t r;
		int   pick;
		bit   held;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= OP_CLEAR;
		nodes_live = 0;
		walk_pos   = 0;
		hdr_fault  = 1'b0;
		strm_fault = 1'b0;
		held       = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// func, symbol, code, len, bit, typed, symbol_out, symbol_valid, status
		add_row(OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b1, 8'h00, 1'b0, ST_OK);
		add_row(OP_INSERT, 8'hA5, 16'h0000, 5'd1,  1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
		add_row(OP_INSERT, 8'h5A, 16'h0002, 5'd2,  1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
		add_row(OP_INSERT, 8'hFF, 16'hFFFF, 5'd2,  1'b1, 1'b1, 8'h00, 1'b0, ST_OK);
		add_row(OP_DECODE, 8'hFF, 16'hFFFF, 5'd31, 1'b0, 1'b1, 8'hA5, 1'b1, ST_OK);
		add_row(OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
		add_row(OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b1, 8'hFF, 1'b1, ST_OK);
		add_row(OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
		add_row(OP_END,    8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h00, 1'b0, ST_TRUNCATED);
		add_row(OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, 1'b0, ST_OK);
		add_row(OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h5A, 1'b1, ST_OK);
		add_row(OP_INSERT, 8'h11, 16'h0000, 5'd1,  1'b0, 1'b1, 8'h00, 1'b0, ST_DUPLICATE);
		add_row(OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h00, 1'b0, ST_BLOCKED);
		add_row(OP_END,    8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h00, 1'b0, ST_BLOCKED);
		add_row(OP_CLEAR,  8'hFF, 16'hFFFF, 5'd31, 1'b1, 1'b1, 8'h00, 1'b0, ST_OK);
		add_row(OP_INSERT, 8'h33, 16'h0001, 5'd0,  1'b0, 1'b1, 8'h00, 1'b0, ST_EMPTY);
		add_row(OP_CLEAR,  8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
		add_row(OP_INSERT, 8'h00, 16'hFFFF, 5'd31, 1'b1, 1'b1, 8'h00, 1'b0, ST_EMPTY);
		add_row(OP_CLEAR,  8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
		add_row(OP_INSERT, 8'h00, 16'h0000, 5'd16, 1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
		add_row(OP_INSERT, 8'h01, 16'h0000, 5'd1,  1'b0, 1'b1, 8'h00, 1'b0, ST_DUPLICATE);
		add_row(OP_CLEAR,  8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
		add_row(OP_INSERT, 8'h80, 16'h0001, 5'd1,  1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
		add_row(OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h00, 1'b0, ST_BAD_BRANCH);
		add_row(OP_END,    8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h00, 1'b0, ST_BLOCKED);
		add_row(OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b1, 8'h80, 1'b1, ST_OK);
		add_row(OP_INSERT, 8'h81, 16'h0003, 5'd2,  1'b0, 1'b1, 8'h00, 1'b0, ST_THROUGH_LEAF);
		for (int i = 0; i < dir_tab.size(); i++) begin
			r = dir_tab[i];
			send_item(r.rq, r.typed, r.res);
		end

		while (items_sent < ITEM_TARGET) begin
			set_idle_mode((items_sent / 160) % 4);
			if (!held && items_sent >= 700) begin
				// starve the output while the input keeps pushing
				held      = 1'b1;
				idle_pct  = 0;
				hold_req  = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 50)
				run_stream_episode(1'b0);
			else if (pick < 60)
				run_stream_episode(1'b1);
			else if (pick < 68)
				run_fill_episode();
			else if (pick < 84) begin
				run_stream_episode(1'b0);
				repeat ($urandom_range(6, 15)) drive_noise();
			end else begin
				repeat ($urandom_range(5, 20)) drive_noise();
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("huffman_tree_decoder: match");
		else
			$display("huffman_tree_decoder: mismatch");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n === 1'b1) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("huffman_tree_decoder: mismatch");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result item arrived with nothing pending");
					mismatches++;
				end else begin
					e = pending_results.pop_front();
					if (m_tdata[7:0] !== e.symbol_out) begin
						$error("symbol_out: expected %0d, got %0d", e.symbol_out, m_tdata[7:0]);
						mismatches++;
					end
					if (m_tuser !== e.symbol_valid) begin
						$error("symbol_valid: expected %0d, got %0d", e.symbol_valid, m_tuser);
						mismatches++;
					end
					if (m_tdata[10:8] !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, m_tdata[10:8]);
						mismatches++;
					end
				end
			end
		end else begin
			quiet = 0;
		end
	end

endmodule
